### src/md5_stream_hasher_macros.svh
// assertion macros for the md5 stream hasher checker
// included by the checker file only
`ifndef MD5_STREAM_HASHER_MACROS_SVH
`define MD5_STREAM_HASHER_MACROS_SVH
// assertion that an implication holds on every clock edge out of reset
`define MD5_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assertion that a signal is low in the cycle after reset is applied
`define MD5_ASSERT_RST(label, clk, rst_n, sig, msg) \
    label: assert property (@(posedge clk) !rst_n |=> !sig) else $error(msg);
`endif

### src/md5_pkg.sv
// package for the md5 stream hasher: constants, types, round tables
// no dependencies
`default_nettype none
package md5_pkg;
    localparam int unsigned QueueDepth = 4;
    localparam logic [31:0] InitA = 32'h67452301;
    localparam logic [31:0] InitB = 32'hefcdab89;
    localparam logic [31:0] InitC = 32'h98badcfe;
    localparam logic [31:0] InitD = 32'h10325476;

    // queue entry handed from front to back
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_digest;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_LEN,
        ST_ROUND,
        ST_OUT
    } t_state;

    function automatic logic [31:0] round_add(input logic [5:0] k);
        logic [31:0] t [64];
        t = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        return t[k];
    endfunction

    function automatic logic [4:0] rot_amount(input logic [3:0] i);
        logic [4:0] t [16];
        t = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
              5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
        return t[i];
    endfunction
endpackage
`default_nettype wire

### src/md5_if.sv
// valid/ready channel interfaces for the md5 stream hasher
// no dependencies
`default_nettype none
interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    modport source (output valid, data_byte, byte_valid, last, input ready);
    modport sink (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word_a;
    logic [31:0] digest_word_b;
    logic [31:0] digest_word_c;
    logic [31:0] digest_word_d;
    modport source (output valid, digest_word_a, digest_word_b, digest_word_c,
                    digest_word_d, input ready);
    modport sink (input valid, digest_word_a, digest_word_b, digest_word_c,
                  digest_word_d, output ready);
endinterface
`default_nettype wire

### src/md5_front.sv
// front end: accepts input items, drops empty ones, queues commands
// depends on md5_pkg
`default_nettype none
module md5_front
    import md5_pkg::*;
#(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_cmd_valid,
    input  wire  i_cmd_pop,
    output t_cmd o_cmd
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd            r_q [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            push;

    assign o_ready     = (r_cnt != AW'(0) + (AW+1)'(DEPTH));
    // items with neither byte nor last carry no work
    assign push        = i_valid && o_ready && (i_cmd.has_byte || i_cmd.last);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_cmd;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_cmd_pop) r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(i_cmd_pop);
        end
    end
endmodule
`default_nettype wire

### src/md5_back.sv
// back end: block packing, padding, 64-round compression, digest register
// depends on md5_pkg
`default_nettype none
module md5_back
    import md5_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_valid,
    input  wire     i_ready,
    output t_digest o_digest
);
    t_state       r_state, n_state;
    logic [31:0]  r_blk [16];
    logic [31:0]  r_ch [4];
    logic [31:0]  r_a, r_b, r_c, r_d;
    logic [63:0]  r_len;
    logic [5:0]   r_fill;
    logic [5:0]   r_rnd;
    logic         r_final;
    logic         r_ovalid;
    t_digest      r_dig;

    // block that ended on a byte carrying last still owes padding;
    // block that ended on the marker or a zero pad owes zeros up to length
    logic         r_pend_last, r_pad_more;

    // byte write request from the sequencer
    logic         wr_en;
    logic [7:0]   wr_byte;
    logic         start_rnd;
    logic         len_wr;
    logic         finish;

    // round function
    logic [1:0]   ph;
    logic [31:0]  f;
    logic [3:0]   g;
    logic [31:0]  sum, rot;
    logic [4:0]   sh;

    always_comb begin
        ph = r_rnd[5:4];
        unique case (ph)
            2'd0: begin f = (r_b & r_c) | (~r_b & r_d); g = r_rnd[3:0]; end
            2'd1: begin
                f = (r_b & r_d) | (r_c & ~r_d);
                g = 4'(r_rnd[3:0] * 3'd5 + 4'd1);
            end
            2'd2: begin f = r_b ^ r_c ^ r_d; g = 4'(r_rnd[3:0] * 2'd3 + 4'd5); end
            default: begin f = r_c ^ (r_b | ~r_d); g = 4'(r_rnd[3:0] * 3'd7); end
        endcase
        sum = r_a + f + round_add(r_rnd) + r_blk[g];
        sh  = rot_amount({ph, r_rnd[1:0]});
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        wr_en     = 1'b0;
        wr_byte   = 8'h00;
        start_rnd = 1'b0;
        len_wr    = 1'b0;
        finish    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.has_byte) begin
                        wr_en   = 1'b1;
                        wr_byte = i_cmd.data;
                        if (r_fill == 6'd63) begin
                            start_rnd = 1'b1;
                            n_state   = ST_ROUND;
                        end else if (i_cmd.last) begin
                            n_state = ST_PAD80;
                        end
                    end else begin
                        n_state   = ST_PAD80;
                    end
                end
            end
            ST_PAD80: begin
                wr_en   = 1'b1;
                wr_byte = 8'h80;
                if (r_fill == 6'd63) begin
                    start_rnd = 1'b1;
                    n_state   = ST_ROUND;
                end else if (r_fill == 6'd55) begin
                    n_state = ST_LEN;
                end else begin
                    n_state = ST_PADZ;
                end
            end
            ST_PADZ: begin
                wr_en = 1'b1;
                if (r_fill == 6'd63) begin
                    start_rnd = 1'b1;
                    n_state   = ST_ROUND;
                end else if (r_fill == 6'd55) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                len_wr    = 1'b1;
                start_rnd = 1'b1;
                n_state   = ST_ROUND;
            end
            ST_ROUND: begin
                if (r_rnd == 6'd63) begin
                    if (r_final) n_state = ST_OUT;
                    else if (r_pend_last) n_state = ST_PAD80;
                    else if (r_pad_more) n_state = (r_fill == 6'd56) ? ST_LEN : ST_PADZ;
                    else n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!r_ovalid || i_ready) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_len       <= '0;
            r_rnd       <= '0;
            r_final     <= 1'b0;
            r_pend_last <= 1'b0;
            r_pad_more  <= 1'b0;
            r_ovalid    <= 1'b0;
            r_ch[0] <= InitA; r_ch[1] <= InitB; r_ch[2] <= InitC; r_ch[3] <= InitD;
        end else begin
            r_state <= n_state;
            if (finish) r_ovalid <= 1'b1;
            else if (o_valid && i_ready) r_ovalid <= 1'b0;
            // byte packing, little-endian
            if (wr_en) begin
                r_fill <= r_fill + 6'd1;
                if (r_state == ST_IDLE) r_len <= r_len + 64'd8;
            end
            if (start_rnd) begin
                r_rnd       <= '0;
                r_final     <= len_wr;
                r_pend_last <= (r_state == ST_IDLE) && i_cmd.last;
                r_pad_more  <= (r_state == ST_PAD80) || (r_state == ST_PADZ);
            end
            if (r_state == ST_ROUND) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_ch[0] <= r_ch[0] + r_d;
                    r_ch[1] <= r_ch[1] + r_b + rot;
                    r_ch[2] <= r_ch[2] + r_b;
                    r_ch[3] <= r_ch[3] + r_c;
                    r_pend_last <= 1'b0;
                    r_pad_more  <= 1'b0;
                end
            end
            if (finish) begin
                r_dig    <= '{a: r_ch[0], b: r_ch[1], c: r_ch[2], d: r_ch[3]};
                r_ch[0] <= InitA; r_ch[1] <= InitB; r_ch[2] <= InitC; r_ch[3] <= InitD;
                r_len   <= '0;
                r_fill  <= '0;
                r_final <= 1'b0;
            end
        end
    end

    // block store and working words
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            unique case (r_fill[1:0])
                2'd0: r_blk[r_fill[5:2]] <= {24'h0, wr_byte};
                2'd1: r_blk[r_fill[5:2]][15:8] <= wr_byte;
                2'd2: r_blk[r_fill[5:2]][23:16] <= wr_byte;
                default: r_blk[r_fill[5:2]][31:24] <= wr_byte;
            endcase
        end
        if (len_wr) begin
            r_blk[14] <= r_len[31:0];
            r_blk[15] <= r_len[63:32];
        end
        if (start_rnd) begin
            r_a <= r_ch[0]; r_b <= r_ch[1]; r_c <= r_ch[2]; r_d <= r_ch[3];
        end else if (r_state == ST_ROUND) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_b + rot;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_digest = r_dig;
endmodule
`default_nettype wire

### src/md5_stream_hasher.sv
// top level of the md5 stream hasher: front queue plus compression back end
// depends on md5_pkg, md5_if, md5_front, md5_back
//
// usage:
//  - input channel carries one item: data_byte, byte_valid and last
//  - output channel carries one digest (words a..d) per message, after last
//  - bytes are taken one per cycle into a four-entry queue while it has room;
//    the back end packs one byte a cycle while it is idle, and runs a full
//    block one round per cycle on a single shared round unit
//  - a message is handled as: its bytes, then the padding bytes at one per
//    cycle, then the length field, each block compressed as it fills, and
//    at last the digest loaded into the output register
//  - items with neither a byte nor last are dropped without a result
//  - the input stalls while the queue is full during compression
//  - when the receiver stalls, the digest stays in the output register; the
//    next message still streams in and is compressed, and its digest waits
//    in the back end, holding off later items, until the register frees
//  - reset loads the md5 initial chaining words and clears the length,
//    fill count, queue and output valid; no clearing pass is needed
//
`default_nettype none
module md5_stream_hasher
    import md5_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    md5_in_if.sink      in_ch,
    md5_out_if.source   out_ch
);
    t_cmd    cmd_in, cmd_q;
    logic    cmd_valid, cmd_pop;
    t_digest dig;

    assign cmd_in = '{has_byte: in_ch.byte_valid, data: in_ch.data_byte,
                      last: in_ch.last};

    md5_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_ch.valid),
        .o_ready    (in_ch.ready),
        .i_cmd      (cmd_in),
        .o_cmd_valid(cmd_valid),
        .i_cmd_pop  (cmd_pop),
        .o_cmd      (cmd_q)
    );

    md5_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd_q),
        .o_cmd_pop  (cmd_pop),
        .o_valid    (out_ch.valid),
        .i_ready    (out_ch.ready),
        .o_digest   (dig)
    );

    assign out_ch.digest_word_a = dig.a;
    assign out_ch.digest_word_b = dig.b;
    assign out_ch.digest_word_c = dig.c;
    assign out_ch.digest_word_d = dig.d;
endmodule
`default_nettype wire

### src/md5_checker.sv
// port-level checker for the md5 stream hasher, bound to the top level
// depends on md5_stream_hasher_macros.svh and md5_if
`default_nettype none
`include "md5_stream_hasher_macros.svh"
module md5_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        out_valid,
    input wire        out_ready,
    input wire [31:0] out_a,
    input wire        in_valid,
    input wire        in_ready
);
    // a stalled digest stays valid and its word a holds its value
    `MD5_ASSERT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready |=> out_valid && $stable(out_a), "digest dropped while stalled")
    // no digest right out of reset
    `MD5_ASSERT_RST(a_rst_valid, i_clk, i_rst_n, out_valid, "digest valid after reset")
    // ready is always known while an item is offered
    `MD5_ASSERT(a_in_known, i_clk, i_rst_n, in_valid |-> !$isunknown(in_ready), "input ready unknown")
    // the queue accepts right after reset
    `MD5_ASSERT(a_rdy_rst, i_clk, i_rst_n, $rose(i_rst_n) |-> in_ready, "not ready after reset")
endmodule

bind md5_stream_hasher md5_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_a    (out_ch.digest_word_a),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready)
);
`default_nettype wire

### tb/sv/tb.sv
// testbench for the md5 stream hasher: random and directed byte messages
// checked against an in-bench md5 predictor; depends on md5_pkg, md5_if
`default_nettype none
module tb;
    import md5_pkg::*;

    logic i_clk;
    logic i_rst_n;
    md5_in_if  in_ch ();
    md5_out_if out_ch ();

    md5_stream_hasher u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // predictor state
    logic [31:0] chain_q [4];
    logic [31:0] blk_q [16];
    logic [63:0] len_bits;
    int unsigned fill_n;
    t_digest     digest_q [$];
    int          mismatch_n;
    int          stall_n;
    bit          quiet;

    localparam logic [31:0] RoundAdd [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    localparam int RotBy [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                  4, 11, 16, 23, 6, 10, 15, 21};

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // one 64-round compression into the chaining words
    task automatic md5_compress();
        logic [31:0] a, b, c, d, f, s, t;
        int g, ph;
        a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
        for (int k = 0; k < 64; k++) begin
            ph = k / 16;
            case (ph)
                0: begin f = (b & c) | (~b & d); g = k; end
                1: begin f = (b & d) | (c & ~d); g = (5 * k + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * k + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * k) % 16; end
            endcase
            s = a + f + RoundAdd[k] + blk_q[g];
            t = (s << RotBy[ph * 4 + k % 4]) | (s >> (32 - RotBy[ph * 4 + k % 4]));
            a = d; d = c; c = b; b = b + t;
        end
        chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
    endtask

    task automatic pack_byte(input logic [7:0] v);
        if (fill_n % 4 == 0) blk_q[fill_n / 4] = '0;
        blk_q[fill_n / 4][8 * (fill_n % 4) +: 8] = v;
        fill_n++;
        if (fill_n == 64) begin
            md5_compress();
            fill_n = 0;
        end
    endtask

    task automatic chain_reset();
        chain_q = '{InitA, InitB, InitC, InitD};
        len_bits = '0;
        fill_n = 0;
    endtask

    // predictor: one accepted item
    task automatic predict_item(input logic [7:0] v, input logic bv, input logic lst);
        t_digest dg;
        if (bv) begin
            pack_byte(v);
            len_bits += 64'd8;
        end
        if (lst) begin
            pack_byte(8'h80);
            if (fill_n > 56) while (fill_n != 0) pack_byte(8'h00);
            while (fill_n < 56) pack_byte(8'h00);
            blk_q[14] = len_bits[31:0];
            blk_q[15] = len_bits[63:32];
            md5_compress();
            fill_n = 0;
            dg = '{a: chain_q[0], b: chain_q[1], c: chain_q[2], d: chain_q[3]};
            digest_q = {digest_q, dg};
            chain_reset();
        end
    endtask

    // send one item, with random idle bursts before it
    task automatic send_item(input logic [7:0] v, input logic bv, input logic lst);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= v;
        in_ch.byte_valid <= bv;
        in_ch.last       <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (bv || lst) predict_item(v, bv, lst);
    endtask

    task automatic send_message(input int n_bytes, input bit noise);
        for (int i = 0; i < n_bytes; i++) begin
            if (noise && $urandom_range(0, 7) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            if (i == n_bytes - 1 && $urandom_range(0, 1))
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            else begin
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                if (i == n_bytes - 1) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
        end
        if (n_bytes == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        while (digest_q.size() != 0) @(posedge i_clk);
    endtask

    // empty message, byte with last, last alone, an ignored item, extreme bytes
    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'haa, 1'b1, 1'b0);
        send_item(8'h55, 1'b1, 1'b1);
    endtask

    // lengths around the padding boundaries
    task automatic test_pad_edges();
        int lens [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        foreach (lens[i]) send_message(lens[i], 1'b0);
    endtask

    // send a message, pause until all digests are out, then send another
    task automatic test_drain_pause();
        send_message(3, 1'b0);
        in_ch.valid <= 1'b0;
        wait_drained();
        send_message(70, 1'b0);
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 900) begin
            int n;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 140)
                                             : $urandom_range(0, 30);
            send_message(n, 1'b1);
            sent += n + 1;
        end
    endtask

    task automatic test_no_idle();
        quiet = 1'b1;
        for (int i = 0; i < 8; i++) send_message($urandom_range(0, 40), 1'b0);
    endtask

    // sink side: stall bursts, compare each digest
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (digest_q.size() == 0) begin
                    mismatch_n++;
                    if (mismatch_n <= 10) $display("unexpected digest %h %h %h %h",
                        out_ch.digest_word_a, out_ch.digest_word_b,
                        out_ch.digest_word_c, out_ch.digest_word_d);
                end else begin
                    t_digest e;
                    e = digest_q.pop_front();
                    if (e.a !== out_ch.digest_word_a || e.b !== out_ch.digest_word_b ||
                        e.c !== out_ch.digest_word_c || e.d !== out_ch.digest_word_d) begin
                        mismatch_n++;
                        if (mismatch_n <= 10)
                            $display("digest mismatch exp %h %h %h %h got %h %h %h %h",
                                e.a, e.b, e.c, e.d, out_ch.digest_word_a,
                                out_ch.digest_word_b, out_ch.digest_word_c,
                                out_ch.digest_word_d);
                    end
                end
            end
            if (quiet) begin
                out_ch.ready <= 1'b1;
            end else if (stall_n != 0) begin
                out_ch.ready <= 1'b0;
                stall_n--;
            end else if ($urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                stall_n = $urandom_range(0, 4);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        #8000000;
        $display("md5_stream_hasher test failed");
        $finish;
    end

    initial begin
        mismatch_n = 0;
        stall_n = 0;
        quiet = 1'b0;
        chain_reset();
        blk_q = '{default: '0};
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.byte_valid = 1'b0;
        in_ch.last = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pad_edges();
        test_drain_pause();
        test_random();
        test_no_idle();
        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (300) @(posedge i_clk);
        if (mismatch_n == 0 && digest_q.size() == 0)
            $display("md5_stream_hasher test passed");
        else
            $display("md5_stream_hasher test failed");
        $finish;
    end
endmodule
`default_nettype wire

### md5_stream_hasher.f
+incdir+src
src/md5_pkg.sv
src/md5_if.sv
src/md5_front.sv
src/md5_back.sv
src/md5_stream_hasher.sv
src/md5_checker.sv
tb/sv/tb.sv
